[rtl/core/voc_pkg.sv]
`default_nettype none
package voc_pkg;

   localparam int NUM_CELLS   = 27;
   localparam int NUM_FACES   = 6;
   localparam int NUM_CORNERS = 4;
   localparam int NIB_W       = 4;
   localparam int VEC_W       = NUM_CELLS * NIB_W;
   localparam int CELL_W      = 5;
   localparam int FACE_W      = 3;
   localparam int AO_W        = 6;
   localparam int LIGHT_W     = 10;
   localparam int LSUM_W      = 6;

   localparam logic [FACE_W-1:0]  LAST_FACE    = 3'd5;
   localparam logic [CELL_W-1:0]  CENTER_CELL  = 5'd13;
   localparam logic [NIB_W-1:0]   FULL_LIGHT   = 4'd15;
   localparam logic [LIGHT_W-1:0] BRIGHT_LIGHT = 10'd600;
   localparam logic [AO_W-1:0]    AO_MAX       = 6'd32;

   // corner cell, side cell, side cell per face and corner
   localparam logic [CELL_W-1:0] OCC_TAB [0:5][0:3][0:2] = '{
      '{'{5'd0,  5'd1,  5'd3},  '{5'd2,  5'd1,  5'd5},
        '{5'd6,  5'd3,  5'd7},  '{5'd8,  5'd5,  5'd7}},
      '{'{5'd18, 5'd19, 5'd21}, '{5'd20, 5'd19, 5'd23},
        '{5'd24, 5'd21, 5'd25}, '{5'd26, 5'd23, 5'd25}},
      '{'{5'd6,  5'd7,  5'd15}, '{5'd8,  5'd7,  5'd17},
        '{5'd24, 5'd15, 5'd25}, '{5'd26, 5'd17, 5'd25}},
      '{'{5'd0,  5'd1,  5'd9},  '{5'd2,  5'd1,  5'd11},
        '{5'd18, 5'd9,  5'd19}, '{5'd20, 5'd11, 5'd19}},
      '{'{5'd0,  5'd3,  5'd9},  '{5'd6,  5'd3,  5'd15},
        '{5'd18, 5'd9,  5'd21}, '{5'd24, 5'd15, 5'd21}},
      '{'{5'd2,  5'd5,  5'd11}, '{5'd8,  5'd5,  5'd17},
        '{5'd20, 5'd11, 5'd23}, '{5'd26, 5'd17, 5'd23}}
   };

   // cells whose shade and light are summed per face and corner
   localparam logic [CELL_W-1:0] SUM_TAB [0:5][0:3][0:3] = '{
      '{'{5'd0,  5'd1,  5'd3,  5'd4},  '{5'd1,  5'd2,  5'd4,  5'd5},
        '{5'd3,  5'd4,  5'd6,  5'd7},  '{5'd4,  5'd5,  5'd7,  5'd8}},
      '{'{5'd18, 5'd19, 5'd21, 5'd22}, '{5'd19, 5'd20, 5'd22, 5'd23},
        '{5'd21, 5'd22, 5'd24, 5'd25}, '{5'd22, 5'd23, 5'd25, 5'd26}},
      '{'{5'd6,  5'd7,  5'd15, 5'd16}, '{5'd7,  5'd8,  5'd16, 5'd17},
        '{5'd15, 5'd16, 5'd24, 5'd25}, '{5'd16, 5'd17, 5'd25, 5'd26}},
      '{'{5'd0,  5'd1,  5'd9,  5'd10}, '{5'd1,  5'd2,  5'd10, 5'd11},
        '{5'd9,  5'd10, 5'd18, 5'd19}, '{5'd10, 5'd11, 5'd19, 5'd20}},
      '{'{5'd0,  5'd3,  5'd9,  5'd12}, '{5'd3,  5'd6,  5'd12, 5'd15},
        '{5'd9,  5'd12, 5'd18, 5'd21}, '{5'd12, 5'd15, 5'd21, 5'd24}},
      '{'{5'd2,  5'd5,  5'd11, 5'd14}, '{5'd5,  5'd8,  5'd14, 5'd17},
        '{5'd11, 5'd14, 5'd20, 5'd23}, '{5'd14, 5'd17, 5'd23, 5'd26}}
   };

   // cell selection handed to one corner lane
   typedef struct packed {
      logic [2:0][CELL_W-1:0] occ;
      logic [3:0][CELL_W-1:0] sum;
   } cells_type;

   // what one corner lane found
   typedef struct packed {
      logic [AO_W-1:0]   ao;
      logic [LSUM_W-1:0] lsum;
   } corner_type;

endpackage
`default_nettype wire

[rtl/core/voxel_corner_occlusion_light_unit.sv]
// Voxel corner occlusion and light unit.
// Input channel (req_*): one beat is the 3x3x3 neighborhood of one voxel:
// opaque mask, light levels and shades of all 27 neighbors.
// Output channel (rsp_*): six beats per input beat, faces 0..5 in order,
// each carrying ao and light sums of the face's four corners; rsp_last marks
// face 5.
// Four corner lanes evaluate one face per cycle in parallel unless the
// receiver stalls, and the output register merges them with the
// bright-center override. The face 0 beat passes through the held
// neighborhood register and then the output register. The face sequencer
// over the held neighborhood sets the rate; the next input beat is taken
// in the cycle the last face moves to the output register.
// Receiver stall: the output register holds its beat and the face sequencer
// pauses; req_ready stays low while a held neighborhood still has faces left.
// Reset: synchronous, active high; clears the held item and output valid.
`default_nettype none
module voxel_corner_occlusion_light_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [26:0] req_opaque_mask,
   input  wire logic [55:0] req_light_low,
   input  wire logic [51:0] req_light_high,
   input  wire logic [55:0] req_shade_low,
   input  wire logic [51:0] req_shade_high,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_face,
   output logic [5:0]       rsp_ao_c0,
   output logic [5:0]       rsp_ao_c1,
   output logic [5:0]       rsp_ao_c2,
   output logic [5:0]       rsp_ao_c3,
   output logic [9:0]       rsp_light_c0,
   output logic [9:0]       rsp_light_c1,
   output logic [9:0]       rsp_light_c2,
   output logic [9:0]       rsp_light_c3,
   output logic             rsp_last
);

   // held neighborhood and face sequencer
   logic                              item_valid_ff, item_valid_in;
   logic [voc_pkg::FACE_W-1:0]        face_ff, face_in;
   logic [voc_pkg::NUM_CELLS-1:0]     mask_ff;
   logic [voc_pkg::VEC_W-1:0]         light_ff;
   logic [voc_pkg::VEC_W-1:0]         shade_ff;

   // output register
   logic                              out_valid_ff, out_valid_in;
   logic [voc_pkg::FACE_W-1:0]        out_face_ff;
   logic                              out_last_ff;
   logic [voc_pkg::AO_W-1:0]          out_ao_ff    [0:3];
   logic [voc_pkg::LIGHT_W-1:0]       out_light_ff [0:3];

   logic                              advance;
   logic                              on_last;
   logic                              accept;
   logic                              bright;
   voc_pkg::cells_type                lane_cells  [0:3];
   voc_pkg::corner_type               lane_result [0:3];

   // handshake control
   assign advance   = item_valid_ff && (!out_valid_ff || rsp_ready);
   assign on_last   = (face_ff == voc_pkg::LAST_FACE);
   assign req_ready = !item_valid_ff || (advance && on_last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      face_in       = face_ff;
      if (advance) begin
         face_in = face_ff + 3'd1;
         if (on_last) begin
            item_valid_in = 1'b0;
         end
      end
      if (accept) begin
         item_valid_in = 1'b1;
         face_in       = '0;
      end
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         face_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         face_ff       <= face_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // item payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff  <= req_opaque_mask;
         light_ff <= {req_light_high, req_light_low};
         shade_ff <= {req_shade_high, req_shade_low};
      end
   end

   // cell selection per lane for the current face
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 3; j++) begin
            lane_cells[c].occ[j] = voc_pkg::OCC_TAB[face_ff][c][j];
         end
         for (int m = 0; m < 4; m++) begin
            lane_cells[c].sum[m] = voc_pkg::SUM_TAB[face_ff][c][m];
         end
      end
   end

   // corner lanes
   for (genvar c = 0; c < 4; c++) begin : g_lane
      voc_lane u_lane (
         .opaque_mask (mask_ff),
         .light_vec   (light_ff),
         .shade_vec   (shade_ff),
         .cells       (lane_cells[c]),
         .result      (lane_result[c])
      );
   end

   // merge: bright center overrides every corner light
   assign bright = (light_ff[{voc_pkg::CENTER_CELL, 2'b00} +: voc_pkg::NIB_W]
                    == voc_pkg::FULL_LIGHT);

   always_ff @(posedge clock) begin
      if (advance) begin
         out_face_ff <= face_ff;
         out_last_ff <= on_last;
         for (int c = 0; c < 4; c++) begin
            out_ao_ff[c] <= lane_result[c].ao;
            if (bright) begin
               out_light_ff[c] <= voc_pkg::BRIGHT_LIGHT;
            end else begin
               out_light_ff[c] <= {4'b0000, lane_result[c].lsum};
            end
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_face     = out_face_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_ao_c0    = out_ao_ff[0];
   assign rsp_ao_c1    = out_ao_ff[1];
   assign rsp_ao_c2    = out_ao_ff[2];
   assign rsp_ao_c3    = out_ao_ff[3];
   assign rsp_light_c0 = out_light_ff[0];
   assign rsp_light_c1 = out_light_ff[1];
   assign rsp_light_c2 = out_light_ff[2];
   assign rsp_light_c3 = out_light_ff[3];

endmodule
`default_nettype wire

[rtl/core/voc_lane.sv]
`default_nettype none
module voc_lane (
   input  wire logic [voc_pkg::NUM_CELLS-1:0] opaque_mask,
   input  wire logic [voc_pkg::VEC_W-1:0]     light_vec,
   input  wire logic [voc_pkg::VEC_W-1:0]     shade_vec,
   input  wire voc_pkg::cells_type            cells,
   output voc_pkg::corner_type                result
);

   logic                       cn;
   logic                       s1;
   logic                       s2;
   logic [1:0]                 level;
   logic [5:0]                 shade_total;
   logic [voc_pkg::LSUM_W-1:0] light_total;
   logic [6:0]                 ao_raw;

   // occlusion level from corner and side cells
   assign cn = opaque_mask[cells.occ[0]];
   assign s1 = opaque_mask[cells.occ[1]];
   assign s2 = opaque_mask[cells.occ[2]];

   always_comb begin
      if (s1 && s2) begin
         level = 2'd3;
      end else begin
         level = {1'b0, cn} + {1'b0, s1} + {1'b0, s2};
      end
   end

   // four-cell sums of shade and light
   always_comb begin
      shade_total = '0;
      light_total = '0;
      for (int m = 0; m < 4; m++) begin
         shade_total = shade_total
                     + {2'b00, shade_vec[{cells.sum[m], 2'b00} +: voc_pkg::NIB_W]};
         light_total = light_total
                     + {2'b00, light_vec[{cells.sum[m], 2'b00} +: voc_pkg::NIB_W]};
      end
   end

   assign result.lsum = light_total;

   // ao saturates at 32
   assign ao_raw = {2'b00, level, 3'b000} + {1'b0, shade_total};
   assign result.ao = (ao_raw > {1'b0, voc_pkg::AO_MAX}) ? voc_pkg::AO_MAX
                                                         : ao_raw[voc_pkg::AO_W-1:0];

endmodule
`default_nettype wire
